FILE: sv/rsfe_pkg.sv
// ----------------------------------------------------------------------------
// rsfe_pkg
// Shared types, codes and helper functions for the raster span fill engine.
// ----------------------------------------------------------------------------
package rsfe_pkg;

    // Fixed field geometry of the command and result items.
    localparam int WORD_BITS = 32;
    localparam int WIDX_W    = 6;   // word index within a row, x fields are 11 bits
    localparam int WCNT_W    = 7;   // number of words an item touches, up to 64

    // Command codes.
    typedef enum logic [1:0] {
        MODE_FILL    = 2'd0,
        MODE_CLEAR   = 2'd1,
        MODE_PATTERN = 2'd2,
        MODE_READ    = 2'd3
    } t_mode;

    // Configuration register indexes.
    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    // Decoded command, handed from the decoder to the sequencer.
    typedef struct packed {
        t_mode                 mode;
        logic                  bad;
        logic                  touch;
        logic [WIDX_W-1:0]     first_w;
        logic [WIDX_W-1:0]     last_w;
        logic [WCNT_W-1:0]     count;
        logic [4:0]            lo_bit;
        logic [4:0]            hi_bit;
        logic [WORD_BITS-1:0]  pat_lo;
        logic [WORD_BITS-1:0]  pat_hi;
    } t_cmd;

    // Mask with the n lowest bits set, n below 32.
    function automatic logic [WORD_BITS-1:0] low_ones(input logic [4:0] n);
        return (WORD_BITS'(1) << n) - WORD_BITS'(1);
    endfunction

    // Bits of word w that lie inside a raster of the given width.
    function automatic logic [WORD_BITS-1:0] width_mask(input logic [6:0] w,
                                                        input logic [10:0] width);
        logic [11:0] base;
        logic [11:0] wid;
        logic [11:0] rem;
        base = {w, 5'b0};
        wid  = {1'b0, width};
        rem  = wid - base;
        if (base >= wid) begin
            return '0;
        end else if (rem >= 12'd32) begin
            return '1;
        end
        return low_ones(rem[4:0]);
    endfunction

endpackage

FILE: sv/rsfe_cmd_decode.sv
// ----------------------------------------------------------------------------
// rsfe_cmd_decode
// Range checks a command and works out the words it covers and its masks.
// ----------------------------------------------------------------------------
module rsfe_cmd_decode
    import rsfe_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic [1:0]        i_mode,
    input  logic [9:0]        i_row,
    input  logic [10:0]       i_x_start,
    input  logic [10:0]       i_x_end,
    input  logic signed [10:0] i_pattern_x,
    input  logic [31:0]       i_pattern_word,
    input  logic [4:0]        i_word_index,
    input  logic [10:0]       i_width,
    input  logic [10:0]       i_height,
    output t_cmd              o_cmd
);

    logic [10:0] eff_w, eff_h;
    logic [10:0] xe_c, xe_m1;
    logic        span_bad;
    logic [WIDX_W-1:0] span_first, span_last;
    logic [WCNT_W-1:0] span_cnt;
    logic [6:0]  row_words;
    logic        rd_bad;
    logic [10:0] px_u, mag, x1;
    logic        neg, pat_bad, hi_ok;
    logic [31:0] p;
    logic [4:0]  sh;
    logic [WIDX_W-1:0] w0;
    logic [6:0]  w1;
    logic [WCNT_W-1:0] pat_cnt;
    logic        row_bad;

    // Clamp the configured size to the storage limits; a zero size counts as one.
    always_comb begin
        if (i_width == 11'd0) begin
            eff_w = 11'd1;
        end else if (32'(i_width) > MAX_WIDTH) begin
            eff_w = 11'(MAX_WIDTH);
        end else begin
            eff_w = i_width;
        end
        if (i_height == 11'd0) begin
            eff_h = 11'd1;
        end else if (32'(i_height) > MAX_HEIGHT) begin
            eff_h = 11'(MAX_HEIGHT);
        end else begin
            eff_h = i_height;
        end
    end

    // Span commands: clip the end, then find the first and last word.
    assign xe_c       = (i_x_end > eff_w) ? eff_w : i_x_end;
    assign xe_m1      = xe_c - 11'd1;
    assign span_bad   = i_x_start > xe_c;
    assign span_first = i_x_start[10:5];
    assign span_last  = xe_m1[10:5];
    assign span_cnt   = (i_x_start == xe_c) ? '0
                      : WCNT_W'({1'b0, span_last} - {1'b0, span_first} + 7'd1);

    // Read command: the word must lie inside the row width.
    assign row_words = 7'((12'(eff_w) + 12'd31) >> 5);
    assign rd_bad    = {2'b0, i_word_index} >= row_words;

    // Pattern command: place the word and split it across two raster words.
    assign px_u    = $unsigned(i_pattern_x);
    assign neg     = px_u[10];
    assign mag     = neg ? (11'd0 - px_u) : px_u;
    assign pat_bad = neg ? (mag >= 11'd32) : (mag >= eff_w);
    assign p       = neg ? (i_pattern_word >> mag[4:0]) : i_pattern_word;
    assign x1      = neg ? 11'd0 : mag;
    assign sh      = x1[4:0];
    assign w0      = x1[10:5];
    assign w1      = {1'b0, w0} + 7'd1;
    assign hi_ok   = (sh != 5'd0) && ({w1, 5'b0} < {1'b0, eff_w});
    assign pat_cnt = (p == 32'd0) ? '0 : (hi_ok ? WCNT_W'(2) : WCNT_W'(1));

    assign row_bad = {1'b0, i_row} >= eff_h;

    // Assemble the decoded command for the selected mode.
    always_comb begin
        o_cmd.mode   = t_mode'(i_mode);
        o_cmd.lo_bit = i_x_start[4:0];
        o_cmd.hi_bit = xe_c[4:0];
        o_cmd.pat_lo = (p << sh) & width_mask({1'b0, w0}, eff_w);
        o_cmd.pat_hi = (p >> (6'd32 - {1'b0, sh})) & width_mask(w1, eff_w);
        unique case (t_mode'(i_mode)) inside
            MODE_FILL, MODE_CLEAR: begin
                o_cmd.bad     = span_bad;
                o_cmd.touch   = !span_bad;
                o_cmd.first_w = span_first;
                o_cmd.last_w  = span_last;
                o_cmd.count   = span_cnt;
            end
            MODE_PATTERN: begin
                o_cmd.bad     = pat_bad;
                o_cmd.touch   = !pat_bad && (p != 32'd0);
                o_cmd.first_w = w0;
                o_cmd.last_w  = hi_ok ? w1[WIDX_W-1:0] : w0;
                o_cmd.count   = pat_cnt;
            end
            default: begin
                o_cmd.bad     = rd_bad;
                o_cmd.touch   = 1'b0;
                o_cmd.first_w = {1'b0, i_word_index};
                o_cmd.last_w  = {1'b0, i_word_index};
                o_cmd.count   = WCNT_W'(1);
            end
        endcase
        // A row outside the raster overrides everything else.
        if (row_bad) begin
            o_cmd.bad   = 1'b1;
            o_cmd.touch = 1'b0;
        end
        if (o_cmd.bad) begin
            o_cmd.count = '0;
        end
    end

endmodule

FILE: sv/rsfe_word_unit.sv
// ----------------------------------------------------------------------------
// rsfe_word_unit
// Read-modify-write unit shared by every word that a command visits.
// ----------------------------------------------------------------------------
module rsfe_word_unit
    import rsfe_pkg::*;
(
    input  t_cmd                  i_cmd,
    input  logic [WIDX_W-1:0]     i_word_idx,
    input  logic [WORD_BITS-1:0]  i_old_word,
    output logic [WORD_BITS-1:0]  o_new_word
);

    logic                 is_first, is_last;
    logic [WORD_BITS-1:0] lo_m, hi_m, mask;

    assign is_first = (i_word_idx == i_cmd.first_w);
    assign is_last  = (i_word_idx == i_cmd.last_w);

    // Span masks trim the first and the last word; inner words are full.
    assign lo_m = is_first ? ~low_ones(i_cmd.lo_bit) : '1;
    assign hi_m = (is_last && (i_cmd.hi_bit != 5'd0)) ? low_ones(i_cmd.hi_bit) : '1;

    always_comb begin
        if (i_cmd.mode == MODE_PATTERN) begin
            mask = is_first ? i_cmd.pat_lo : i_cmd.pat_hi;
        end else begin
            mask = lo_m & hi_m;
        end
    end

    // Clear drops the masked bits, every other write sets them.
    assign o_new_word = (i_cmd.mode == MODE_CLEAR) ? (i_old_word & ~mask)
                                                   : (i_old_word | mask);

endmodule

FILE: sv/raster_span_fill_engine_unit.sv
// ----------------------------------------------------------------------------
// raster_span_fill_engine_unit
// One-bit raster with span fill, span clear, pattern OR and word read.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the input channel (i_in_valid / o_in_stall), one item
//   per command; each gives exactly one result item on the output channel
//   (o_out_valid / i_out_stall) with read data, status and rows used.
//   The user must write width and height on the configuration channel
//   (i_cfg_valid / o_cfg_ready, index 0 width, 1 height) only while
//   idle; the block itself does not enforce this.
//   A command visiting N raster words is worked one word at a time: the
//   single raster memory is read for one word per cycle and the modified word
//   written back in the following cycle, overlapped. A full 1024-pixel
//   span is 32 words; a pattern is at most 2 words, a read 1 word, an
//   ignored command none. One command is in work at a time.
//   The result sits in an output register, so the next command is taken
//   while the receiver stalls; the engine only waits if a second result is
//   ready before the first was taken.
//   After reset the raster is swept to zero one word per cycle, covering all
//   MAX_HEIGHT * ceil(MAX_WIDTH / 32) words (32768 at the defaults); no
//   command is accepted meanwhile, configuration writes are.
// ----------------------------------------------------------------------------
module raster_span_fill_engine_unit
    import rsfe_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic [9:0]         i_row,
    input  logic [10:0]        i_x_start,
    input  logic [10:0]        i_x_end,
    input  logic signed [10:0] i_pattern_x,
    input  logic [31:0]        i_pattern_word,
    input  logic [4:0]         i_word_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_read_data,
    output logic               o_status,
    output logic [10:0]        o_rows_used,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [10:0]        i_cfg_data
);

    localparam int WPR   = (MAX_WIDTH + 31) / 32;
    localparam int DEPTH = MAX_HEIGHT * WPR;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RUN   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [10:0]         r_width, n_width;
    logic [10:0]         r_height, n_height;
    logic [10:0]         r_high, n_high;
    t_cmd                r_cmd, n_cmd;
    logic [AW-1:0]       r_base, n_base;
    logic [WIDX_W-1:0]   r_rd_w, n_rd_w;
    logic [WIDX_W-1:0]   r_wr_w, n_wr_w;
    logic [WCNT_W-1:0]   r_left, n_left;
    logic                r_pend, n_pend;
    logic [31:0]         r_res_data, n_res_data;
    logic                r_out_valid, n_out_valid;
    logic [31:0]         r_out_data, n_out_data;
    logic                r_out_status, n_out_status;
    logic [10:0]         r_out_rows, n_out_rows;
    logic [31:0]         r_rdata;

    logic [31:0]         mem [DEPTH];

    t_cmd                dec_cmd;
    logic [31:0]         new_word;
    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [31:0]         wr_data;
    logic                out_free;

    rsfe_cmd_decode #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_decode (
        .i_mode         (i_mode),
        .i_row          (i_row),
        .i_x_start      (i_x_start),
        .i_x_end        (i_x_end),
        .i_pattern_x    (i_pattern_x),
        .i_pattern_word (i_pattern_word),
        .i_word_index   (i_word_index),
        .i_width        (r_width),
        .i_height       (r_height),
        .o_cmd          (dec_cmd)
    );

    rsfe_word_unit u_word (
        .i_cmd      (r_cmd),
        .i_word_idx (r_wr_w),
        .i_old_word (r_rdata),
        .o_new_word (new_word)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_status    = r_out_status;
    assign o_rows_used = r_out_rows;

    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_addr  = r_base + AW'(r_rd_w);

    // Sequencer: clearing sweep, command capture and the word loop.
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_high     = r_high;
        n_cmd      = r_cmd;
        n_base     = r_base;
        n_rd_w     = r_rd_w;
        n_wr_w     = r_wr_w;
        n_left     = r_left;
        n_pend     = r_pend;
        n_res_data = r_res_data;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_base + AW'(r_wr_w);
        wr_data    = new_word;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd      = dec_cmd;
                    n_base     = AW'(32'(i_row) * WPR);
                    n_rd_w     = dec_cmd.first_w;
                    n_left     = dec_cmd.count;
                    n_pend     = 1'b0;
                    n_res_data = '0;
                    if (dec_cmd.touch && (r_high <= {1'b0, i_row})) begin
                        n_high = {1'b0, i_row} + 11'd1;
                    end
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                // Issue the next read while the previous word is written back.
                if (r_left != '0) begin
                    rd_en  = 1'b1;
                    n_rd_w = r_rd_w + WIDX_W'(1);
                    n_wr_w = r_rd_w;
                    n_left = r_left - WCNT_W'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end
                if (r_pend) begin
                    if (r_cmd.mode == MODE_READ) begin
                        n_res_data = r_rdata;
                    end else begin
                        wr_en = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration registers.
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  n_width  = i_cfg_data;
                CFG_HEIGHT: n_height = i_cfg_data;
                default:    n_width  = r_width;
            endcase
        end
    end

    // Output register, loaded when the engine finishes and the slot is free.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_rows   = r_out_rows;
        if ((r_state == S_DONE) && out_free) begin
            n_out_valid  = 1'b1;
            n_out_data   = r_res_data;
            n_out_status = r_cmd.bad;
            n_out_rows   = r_high;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_width     <= 11'd1024;
            r_height    <= 11'd1024;
            r_high      <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_width     <= n_width;
            r_height    <= n_height;
            r_high      <= n_high;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_base       <= n_base;
        r_rd_w       <= n_rd_w;
        r_wr_w       <= n_wr_w;
        r_res_data   <= n_res_data;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_rows   <= n_out_rows;
    end

    // Raster memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/rsfe_port_checker.sv
// ----------------------------------------------------------------------------
// rsfe_port_checker
// Port-level checks of the raster span fill engine, bound to the top level.
// ----------------------------------------------------------------------------
module rsfe_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_read_data,
    input logic        o_status,
    input logic [10:0] o_rows_used
);

    // A result item that is stalled stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_read_data) && $stable(o_status) && $stable(o_rows_used))
        else $error("result item changed while stalled");

    // An ignored command never returns read data.
    a_bad_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_read_data == 32'd0)
        else $error("ignored command returned data");

    // The engine works on one command at a time.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted while one is in work");

endmodule

bind raster_span_fill_engine_unit rsfe_port_checker u_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_read_data (o_read_data),
    .o_status    (o_status),
    .o_rows_used (o_rows_used)
);
